/* sv/aging_priority_scheduler_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the aging priority scheduler
// Shorthand forms of clocked implication properties with reset disable.
// ----------------------------------------------------------------------------
`ifndef AGING_PRIORITY_SCHEDULER_TOP_MACROS_SVH
`define AGING_PRIORITY_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication: when cond holds, conseq holds too.
`define APS_ASSERT_NOW(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication: when cond holds, conseq holds in the next cycle.
`define APS_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

/* sv/aps_pkg.sv */
// ----------------------------------------------------------------------------
// Aging priority scheduler package
// Field widths, command and status codes, cell types and priority helpers.
// ----------------------------------------------------------------------------
package aps_pkg;

    localparam int SLOT_W        = 4;
    localparam int PRIO_W        = 6;
    localparam int COUNT_W       = 5;
    localparam int CMD_W         = 2;
    localparam int STATUS_W      = 2;
    localparam int MAX_TASKS_DEF = 16;
    localparam int SLOT_LIMIT    = 2 ** SLOT_W;
    localparam int IN_DATA_W     = ((SLOT_W + PRIO_W + 7) / 8) * 8;
    localparam int OUT_DATA_W    = ((SLOT_W + COUNT_W + 7) / 8) * 8;

    typedef logic [SLOT_W-1:0]         slot_t;
    typedef logic signed [PRIO_W-1:0]  prio_t;
    typedef logic [COUNT_W-1:0]        count_t;

    // Aging stops here; a restarted task may sit lower, down to the type minimum
    localparam prio_t AGE_FLOOR = prio_t'(-20);
    localparam prio_t PRIO_MIN  = prio_t'(-32);

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND,
        CMD_REMOVE,
        CMD_SETPRIO,
        CMD_PICK
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE,
        ST_IGNORED,
        ST_EMPTY
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    typedef enum logic [2:0] {
        C_HOLD,
        C_APPEND,
        C_REMOVE,
        C_SETPRIO,
        C_ROTATE,
        C_AGE
    } cell_op_t;

    // One queue position: task slot and its two priorities
    typedef struct packed {
        slot_t slot;
        prio_t sprio;
        prio_t dprio;
    } entry_t;

    // Broadcast to every cell of the queue chain
    typedef struct packed {
        cell_op_t op;
        slot_t    slot;
        prio_t    prio;
    } cell_ctrl_t;

    // Scan control for the minimum tracker
    typedef struct packed {
        logic first;
        logic sample;
    } pick_ctrl_t;

    // Age one step, clamped at the floor
    function automatic prio_t age_prio(input prio_t d);
        return (d <= AGE_FLOOR) ? AGE_FLOOR : d - prio_t'(1);
    endfunction

    // Dynamic value of a freshly picked task: static minus one, clamped
    function automatic prio_t restart_prio(input prio_t s);
        return (s == PRIO_MIN) ? PRIO_MIN : s - prio_t'(1);
    endfunction

endpackage

/* sv/aps_cell.sv */
// ----------------------------------------------------------------------------
// Aging priority scheduler queue cell
// Holds one queue position and moves it along the chain on remove and scan.
// ----------------------------------------------------------------------------
module aps_cell (
    input  logic               clk,
    input  aps_pkg::cell_ctrl_t ctrl,
    input  logic               valid,
    input  logic               tail,
    input  logic               wrap,
    input  logic               found_in,
    input  aps_pkg::entry_t    nbr_in,
    input  aps_pkg::entry_t    head_in,
    output logic               match,
    output logic               found_out,
    output aps_pkg::entry_t    entry
);

    aps_pkg::entry_t entry_reg;
    aps_pkg::entry_t entry_next;

    // Compare the held slot with the broadcast one
    assign match     = valid && (entry_reg.slot == ctrl.slot);
    // Everything from the removed position onward closes the gap
    assign found_out = found_in | match;
    assign entry     = entry_reg;

    // Select the next content of this position
    always_comb
    begin
        entry_next = entry_reg;
        unique case (ctrl.op)
            aps_pkg::C_HOLD:
            begin
                entry_next = entry_reg;
            end
            aps_pkg::C_APPEND:
            begin
                if (tail)
                begin
                    entry_next.slot  = ctrl.slot;
                    entry_next.sprio = ctrl.prio;
                    entry_next.dprio = ctrl.prio;
                end
            end
            aps_pkg::C_REMOVE:
            begin
                if (found_out)
                begin
                    entry_next = nbr_in;
                end
            end
            aps_pkg::C_SETPRIO:
            begin
                if (match)
                begin
                    entry_next.sprio = ctrl.prio;
                    entry_next.dprio = ctrl.prio;
                end
            end
            aps_pkg::C_ROTATE:
            begin
                entry_next = wrap ? head_in : nbr_in;
            end
            aps_pkg::C_AGE:
            begin
                if (valid)
                begin
                    if (match)
                    begin
                        entry_next.dprio = aps_pkg::restart_prio(entry_reg.sprio);
                    end
                    else
                    begin
                        entry_next.dprio = aps_pkg::age_prio(entry_reg.dprio);
                    end
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

/* sv/aps_picker.sv */
// ----------------------------------------------------------------------------
// Aging priority scheduler minimum tracker
// Watches the queue head while the chain rotates and keeps the winner.
// ----------------------------------------------------------------------------
module aps_picker (
    input  logic                clk,
    input  aps_pkg::pick_ctrl_t ctrl,
    input  aps_pkg::slot_t      head_slot,
    input  aps_pkg::prio_t      head_prio,
    output aps_pkg::slot_t      chosen
);

    aps_pkg::slot_t best_slot_reg;
    aps_pkg::slot_t best_slot_next;
    aps_pkg::prio_t best_prio_reg;
    aps_pkg::prio_t best_prio_next;
    aps_pkg::slot_t first_slot_reg;
    aps_pkg::slot_t first_slot_next;
    aps_pkg::prio_t first_prio_reg;
    aps_pkg::prio_t first_prio_next;

    // Track the minimum; later ties replace the running winner
    always_comb
    begin
        best_slot_next  = best_slot_reg;
        best_prio_next  = best_prio_reg;
        first_slot_next = first_slot_reg;
        first_prio_next = first_prio_reg;
        priority if (ctrl.first)
        begin
            best_slot_next  = head_slot;
            best_prio_next  = head_prio;
            first_slot_next = head_slot;
            first_prio_next = head_prio;
        end
        else if (ctrl.sample && (head_prio <= best_prio_reg))
        begin
            best_slot_next = head_slot;
            best_prio_next = head_prio;
        end
    end

    always_ff @(posedge clk)
    begin
        best_slot_reg  <= best_slot_next;
        best_prio_reg  <= best_prio_next;
        first_slot_reg <= first_slot_next;
        first_prio_reg <= first_prio_next;
    end

    // A queue head tied with the minimum wins over every other entry
    assign chosen = (first_prio_reg == best_prio_reg) ? first_slot_reg : best_slot_reg;

endmodule

/* sv/aging_priority_scheduler_top.sv */
// ----------------------------------------------------------------------------
// Aging priority scheduler
// Ready queue of task slots held in a chain of cells, with aging picks.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command word: s_tuser is the command, s_tdata the task
//   slot and its static priority. m_* returns one result word per command:
//   m_tuser is the status, m_tdata the picked task and the queue count.
//   Append, remove and set priority finish in the accept cycle; the result
//   is valid from the next cycle and the next word can be taken right away.
//   A pick on a queue of n tasks rotates the cell chain once round in the
//   scan state, past the minimum tracker, then ages all cells together in
//   the update state, which also loads the result; the next command is
//   taken after that. An empty pick loads its result in the accept cycle.
//   The result register frees up in the cycle it is taken, so a command is
//   accepted while an older result is handed over. While m_tready is low
//   and a result waits, s_tready stays low and a pick holds before aging.
//   Reset empties the queue and drops any pending result; the priority
//   cells hold no meaningful value until a task is appended.
// ----------------------------------------------------------------------------
module aging_priority_scheduler_top #(
    parameter int MAX_TASKS = aps_pkg::MAX_TASKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, low bit up: task_slot[3:0], priority_req[9:4], zero pad
    input  logic [aps_pkg::IN_DATA_W-1:0]   s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [aps_pkg::CMD_W-1:0]       s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, low bit up: chosen_task[3:0], queue_count[8:4], zero pad
    output logic [aps_pkg::OUT_DATA_W-1:0]  m_tdata,
    // m_tuser: status[1:0]
    output logic [aps_pkg::STATUS_W-1:0]    m_tuser
);

    // Only slots below both the limit and the slot field range can be queued
    localparam int NSLOT = (MAX_TASKS < aps_pkg::SLOT_LIMIT) ? MAX_TASKS
                                                             : aps_pkg::SLOT_LIMIT;

    aps_pkg::cmd_t      in_cmd;
    aps_pkg::slot_t     in_slot;
    aps_pkg::prio_t     in_prio;
    logic               in_accept;
    logic               out_free;
    logic               slot_bad;
    logic               member;

    aps_pkg::state_t    state_reg;
    aps_pkg::state_t    state_next;
    aps_pkg::count_t    cnt_reg;
    aps_pkg::count_t    cnt_next;
    aps_pkg::count_t    length_reg;
    aps_pkg::count_t    length_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    aps_pkg::slot_t     out_chosen_reg;
    aps_pkg::status_t   out_status_reg;
    aps_pkg::count_t    out_count_reg;

    logic               load_res;
    aps_pkg::slot_t     res_chosen;
    aps_pkg::status_t   res_status;

    aps_pkg::cell_ctrl_t cell_ctrl;
    aps_pkg::pick_ctrl_t pick_ctrl;
    aps_pkg::slot_t      chosen;

    aps_pkg::entry_t    ent [NSLOT];
    logic [NSLOT-1:0]   match_vec;
    logic [NSLOT:0]     found;

    // Unpack the command word
    assign in_cmd    = aps_pkg::cmd_t'(s_tuser);
    assign in_slot   = s_tdata[aps_pkg::SLOT_W-1:0];
    assign in_prio   = s_tdata[aps_pkg::SLOT_W +: aps_pkg::PRIO_W];
    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == aps_pkg::S_IDLE) && out_free;
    assign in_accept = s_tvalid && s_tready;
    assign slot_bad  = int'(in_slot) >= MAX_TASKS;
    assign member    = |match_vec;
    assign found[0]  = 1'b0;

    // Queue chain: position 0 is the head
    for (genvar i = 0; i < NSLOT; i++)
    begin : g_cell
        aps_pkg::entry_t nbr;
        if (i == NSLOT - 1)
        begin : g_last
            assign nbr = ent[0];
        end
        else
        begin : g_mid
            assign nbr = ent[i+1];
        end

        aps_cell u_cell (
            .clk       (clk),
            .ctrl      (cell_ctrl),
            .valid     (aps_pkg::count_t'(i) < length_reg),
            .tail      (aps_pkg::count_t'(i) == length_reg),
            .wrap      (aps_pkg::count_t'(i) == (length_reg - aps_pkg::count_t'(1))),
            .found_in  (found[i]),
            .nbr_in    (nbr),
            .head_in   (ent[0]),
            .match     (match_vec[i]),
            .found_out (found[i+1]),
            .entry     (ent[i])
        );
    end

    aps_picker u_picker (
        .clk       (clk),
        .ctrl      (pick_ctrl),
        .head_slot (ent[0].slot),
        .head_prio (ent[0].dprio),
        .chosen    (chosen)
    );

    // Next state: one rotation per scan cycle, then the aging update
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            aps_pkg::S_IDLE:
            begin
                if (in_accept && (in_cmd == aps_pkg::CMD_PICK) && (length_reg != '0))
                begin
                    state_next = aps_pkg::S_SCAN;
                    cnt_next   = '0;
                end
            end
            aps_pkg::S_SCAN:
            begin
                cnt_next = cnt_reg + aps_pkg::count_t'(1);
                if (cnt_reg == (length_reg - aps_pkg::count_t'(1)))
                begin
                    state_next = aps_pkg::S_UPDATE;
                end
            end
            aps_pkg::S_UPDATE:
            begin
                if (out_free)
                begin
                    state_next = aps_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aps_pkg::S_IDLE;
            end
        endcase
    end

    // Drive the chain, the tracker and the result
    always_comb
    begin
        cell_ctrl.op   = aps_pkg::C_HOLD;
        cell_ctrl.slot = in_slot;
        cell_ctrl.prio = in_prio;
        pick_ctrl      = '0;
        length_next    = length_reg;
        load_res       = 1'b0;
        res_chosen     = '0;
        res_status     = aps_pkg::ST_DONE;
        unique case (state_reg)
            aps_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    priority if (in_cmd == aps_pkg::CMD_PICK)
                    begin
                        if (length_reg == '0)
                        begin
                            load_res   = 1'b1;
                            res_status = aps_pkg::ST_EMPTY;
                        end
                    end
                    else if (slot_bad)
                    begin
                        load_res   = 1'b1;
                        res_status = aps_pkg::ST_IGNORED;
                    end
                    else
                    begin
                        load_res = 1'b1;
                        unique case (in_cmd)
                            aps_pkg::CMD_APPEND:
                            begin
                                if (member || (length_reg >= aps_pkg::count_t'(NSLOT)))
                                begin
                                    res_status = aps_pkg::ST_IGNORED;
                                end
                                else
                                begin
                                    cell_ctrl.op = aps_pkg::C_APPEND;
                                    length_next  = length_reg + aps_pkg::count_t'(1);
                                end
                            end
                            aps_pkg::CMD_REMOVE:
                            begin
                                if (!member)
                                begin
                                    res_status = aps_pkg::ST_IGNORED;
                                end
                                else
                                begin
                                    cell_ctrl.op = aps_pkg::C_REMOVE;
                                    length_next  = length_reg - aps_pkg::count_t'(1);
                                end
                            end
                            aps_pkg::CMD_SETPRIO:
                            begin
                                cell_ctrl.op = aps_pkg::C_SETPRIO;
                            end
                            default:
                            begin
                                cell_ctrl.op = aps_pkg::C_HOLD;
                            end
                        endcase
                    end
                end
            end
            aps_pkg::S_SCAN:
            begin
                cell_ctrl.op     = aps_pkg::C_ROTATE;
                pick_ctrl.first  = (cnt_reg == '0);
                pick_ctrl.sample = 1'b1;
            end
            aps_pkg::S_UPDATE:
            begin
                if (out_free)
                begin
                    cell_ctrl.op   = aps_pkg::C_AGE;
                    cell_ctrl.slot = chosen;
                    load_res       = 1'b1;
                    res_chosen     = chosen;
                end
            end
            default:
            begin
                cell_ctrl.op = aps_pkg::C_HOLD;
            end
        endcase
    end

    // Result register: load a new word or drop the one taken
    always_comb
    begin
        priority if (load_res)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= aps_pkg::S_IDLE;
            cnt_reg       <= '0;
            length_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            length_reg    <= length_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the result payload until the next load
    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            out_chosen_reg <= res_chosen;
            out_status_reg <= res_status;
            out_count_reg  <= length_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = aps_pkg::OUT_DATA_W'({out_count_reg, out_chosen_reg});
    assign m_tuser  = out_status_reg;

endmodule

/* sv/aps_checker.sv */
// ----------------------------------------------------------------------------
// Aging priority scheduler port checker
// Watches the result channel of the top level and flags broken results.
// ----------------------------------------------------------------------------
`include "aging_priority_scheduler_top_macros.svh"

module aps_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [aps_pkg::CMD_W-1:0]       s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [aps_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [aps_pkg::STATUS_W-1:0]    m_tuser
);

    logic in_word;
    logic pick_word;

    // Track whether a pick command is being taken
    assign in_word   = s_tvalid && s_tready;
    assign pick_word = in_word && (s_tuser == aps_pkg::CMD_PICK);

    // Stalled result word holds
    `APS_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Queue count never exceeds the slot limit
    `APS_ASSERT_NOW(a_count_range, clk, rst_n, m_tvalid, m_tdata[aps_pkg::SLOT_W +: aps_pkg::COUNT_W] <= aps_pkg::COUNT_W'(aps_pkg::SLOT_LIMIT), "queue count out of range")

    // Empty pick reports no task and an empty queue
    `APS_ASSERT_NOW(a_empty_zero, clk, rst_n, m_tvalid && (m_tuser == aps_pkg::ST_EMPTY), m_tdata[aps_pkg::SLOT_W +: aps_pkg::COUNT_W] == '0 && m_tdata[aps_pkg::SLOT_W-1:0] == '0, "empty pick with nonzero fields")

    // A pick blocks new commands in the next cycle unless it found the queue empty
    `APS_ASSERT_NEXT(a_pick_busy, clk, rst_n, pick_word, !s_tready || (m_tvalid && (m_tuser == aps_pkg::ST_EMPTY)), "command taken right after a pick")

    // Results with a status other than done carry no task
    `APS_ASSERT_NOW(a_chosen_zero, clk, rst_n, m_tvalid && (m_tuser != aps_pkg::ST_DONE), m_tdata[aps_pkg::SLOT_W-1:0] == '0, "task reported with non-done status")

endmodule

bind aging_priority_scheduler_top aps_checker u_aps_checker (.*);

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// Aging priority scheduler testbench
// Drives command words into the scheduler and tracks the ready queue, both
// priorities of every slot and the aging of picks on the side. Each result
// word is checked against the predicted outcome, field by field. Random gaps
// on the command side and stalls on the result side vary from phase to phase.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = aps_pkg::MAX_TASKS_DEF;
    localparam int PAD_IN_W  = aps_pkg::IN_DATA_W - aps_pkg::SLOT_W - aps_pkg::PRIO_W;
    localparam int CNT_LO    = aps_pkg::SLOT_W;
    localparam int PAD_LO    = aps_pkg::SLOT_W + aps_pkg::COUNT_W;

    // Expected contents of one result word
    typedef struct packed {
        aps_pkg::slot_t   chosen;
        aps_pkg::status_t status;
        aps_pkg::count_t  count;
    } outcome_t;

    // Tracks the ready queue and holds the outcomes still owed by the block
    class ready_queue_tracker;
        aps_pkg::slot_t order[$];
        bit             queued[NUM_SLOTS];
        aps_pkg::prio_t base_prio[NUM_SLOTS];
        aps_pkg::prio_t live_prio[NUM_SLOTS];
        outcome_t       outcome_q[$];
        int             errors;

        function new();
            order.delete();
            outcome_q.delete();
            errors = 0;
            foreach (queued[i])
            begin
                queued[i]    = 1'b0;
                base_prio[i] = '0;
                live_prio[i] = '0;
            end
        endfunction

        function int waiting();
            return outcome_q.size();
        endfunction

        // Work out the outcome of one accepted command word
        function void note_command(aps_pkg::cmd_t op, aps_pkg::slot_t slot,
                                   aps_pkg::prio_t prio);
            outcome_t o;
            int n;
            int best;
            int s;
            int t;
            int i;
            o.chosen = '0;
            o.status = aps_pkg::ST_DONE;
            case (op)
                aps_pkg::CMD_PICK:
                begin
                    n = order.size();
                    if (n == 0)
                        o.status = aps_pkg::ST_EMPTY;
                    else
                    begin
                        // Scan from the second entry round to the head, later ties win
                        best = order[0];
                        for (i = 1; i <= n; i++)
                        begin
                            s = order[i % n];
                            if (live_prio[s] <= live_prio[best])
                                best = s;
                        end
                        // Age every queued entry, clamped at the floor
                        for (i = 0; i < n; i++)
                        begin
                            t = int'(live_prio[order[i]]) - 1;
                            if (t < int'(aps_pkg::AGE_FLOOR))
                                t = int'(aps_pkg::AGE_FLOOR);
                            live_prio[order[i]] = aps_pkg::prio_t'(t);
                        end
                        // Restart the chosen task from its static value
                        t = int'(base_prio[best]) - 1;
                        if (t < int'(aps_pkg::PRIO_MIN))
                            t = int'(aps_pkg::PRIO_MIN);
                        live_prio[best] = aps_pkg::prio_t'(t);
                        o.chosen = aps_pkg::slot_t'(best);
                    end
                end
                aps_pkg::CMD_APPEND:
                begin
                    if (queued[slot] || order.size() >= NUM_SLOTS)
                        o.status = aps_pkg::ST_IGNORED;
                    else
                    begin
                        base_prio[slot] = prio;
                        live_prio[slot] = prio;
                        order.push_back(slot);
                        queued[slot] = 1'b1;
                    end
                end
                aps_pkg::CMD_REMOVE:
                begin
                    if (!queued[slot])
                        o.status = aps_pkg::ST_IGNORED;
                    else
                    begin
                        for (i = 0; i < order.size(); i++)
                        begin
                            if (order[i] == slot)
                            begin
                                order.delete(i);
                                break;
                            end
                        end
                        queued[slot] = 1'b0;
                    end
                end
                default:
                begin
                    base_prio[slot] = prio;
                    live_prio[slot] = prio;
                end
            endcase
            o.count = aps_pkg::count_t'(order.size());
            outcome_q.push_back(o);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        // Compare one result word with the oldest outcome owed
        task check_result(logic [aps_pkg::OUT_DATA_W-1:0] word,
                          logic [aps_pkg::STATUS_W-1:0] st);
            outcome_t o;
            if (outcome_q.size() == 0)
                report_mismatch($sformatf("result word %h/%h with nothing pending", word, st));
            else
            begin
                o = outcome_q.pop_front();
                if (word[aps_pkg::SLOT_W-1:0] !== o.chosen)
                    report_mismatch($sformatf("chosen_task %0d, predicted %0d",
                                              word[aps_pkg::SLOT_W-1:0], o.chosen));
                if (st !== o.status)
                    report_mismatch($sformatf("status %0d, predicted %0d", st, o.status));
                if (word[PAD_LO-1:CNT_LO] !== o.count)
                    report_mismatch($sformatf("queue_count %0d, predicted %0d",
                                              word[PAD_LO-1:CNT_LO], o.count));
                if (word[aps_pkg::OUT_DATA_W-1:PAD_LO] !== '0)
                    report_mismatch($sformatf("pad bits of result word %h not zero", word));
            end
        endtask
    endclass

    logic                             clk      = 1'b0;
    logic                             rst_n    = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [aps_pkg::IN_DATA_W-1:0]    s_tdata  = '0;
    logic [aps_pkg::CMD_W-1:0]        s_tuser  = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [aps_pkg::OUT_DATA_W-1:0]   m_tdata;
    logic [aps_pkg::STATUS_W-1:0]     m_tuser;

    ready_queue_tracker sb = new();

    int tx_busy = 0;
    int rx_busy = 0;
    int rx_hold = 0;
    int rx_gap;

    aging_priority_scheduler_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #6 clk = ~clk;

    // Gap length: none outside busy_pct percent of calls; otherwise mostly short, a few long
    function automatic int pick_gap(int busy_pct);
        if (int'($urandom_range(0, 99)) >= busy_pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return int'($urandom_range(10, 40));
        return int'($urandom_range(1, 3));
    endfunction

    // Priority mostly within the usual range, now and then any 6-bit value
    function automatic aps_pkg::prio_t rand_prio();
        if ($urandom_range(0, 7) == 0)
            return aps_pkg::prio_t'($urandom_range(0, 63));
        return aps_pkg::prio_t'(int'($urandom_range(0, 40)) - 20);
    endfunction

    // Stall the result side at random
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold = rx_hold - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            rx_gap = pick_gap(rx_busy);
            if (rx_gap > 0)
            begin
                rx_hold = rx_gap - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Note accepted command words and check result words
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_command(aps_pkg::cmd_t'(s_tuser), s_tdata[aps_pkg::SLOT_W-1:0],
                                s_tdata[aps_pkg::SLOT_W+aps_pkg::PRIO_W-1:aps_pkg::SLOT_W]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
        end
    end

    // Present one command word from a falling edge and hold it until taken
    task send_cmd(aps_pkg::cmd_t op, aps_pkg::slot_t slot, aps_pkg::prio_t prio, int gap);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_IN_W{1'b0}}, prio, slot};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every owed result word has come back
    task drain();
        s_tvalid <= 1'b0;
        while (sb.waiting() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        #8_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    initial
    begin : stimulus
        int wa[7];
        int wr[7];
        int ws[7];
        int txp[7];
        int rxp[7];
        int p;
        int k;
        int r;
        aps_pkg::cmd_t op;

        // Append, remove, set priority weights per phase; pick takes the rest
        wa = '{50, 25, 10, 10, 35, 20, 30};
        wr = '{10, 15, 10, 50, 20, 10, 20};
        ws = '{10, 15, 10, 10, 15, 30, 10};
        txp = '{30,  0, 50, 20, 40, 10, 60};
        rxp = '{30,  0, 20, 50, 40, 60, 10};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: empty queue, absent and duplicate tasks, ties, extremes
        tx_busy = 0;
        rx_busy = 20;
        send_cmd(aps_pkg::CMD_PICK,    4'd0,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_REMOVE,  4'd3,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_SETPRIO, 4'd5,  6'sd31,  1);
        send_cmd(aps_pkg::CMD_APPEND,  4'd0,  -6'sd32, 0);
        send_cmd(aps_pkg::CMD_APPEND,  4'd15, 6'sd31,  0);
        send_cmd(aps_pkg::CMD_APPEND,  4'd7,  6'sd0,   2);
        send_cmd(aps_pkg::CMD_APPEND,  4'd7,  -6'sd5,  0);
        send_cmd(aps_pkg::CMD_APPEND,  4'd9,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_APPEND,  4'd5,  6'sd20,  0);
        send_cmd(aps_pkg::CMD_PICK,    4'd0,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_PICK,    4'd0,  6'sd0,   1);
        send_cmd(aps_pkg::CMD_PICK,    4'd0,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_SETPRIO, 4'd15, -6'sd20, 0);
        send_cmd(aps_pkg::CMD_PICK,    4'd0,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_SETPRIO, 4'd9,  -6'sd32, 0);
        send_cmd(aps_pkg::CMD_PICK,    4'd0,  6'sd0,   3);
        send_cmd(aps_pkg::CMD_REMOVE,  4'd7,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_REMOVE,  4'd0,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_REMOVE,  4'd5,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_PICK,    4'd0,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_REMOVE,  4'd15, 6'sd0,   0);
        send_cmd(aps_pkg::CMD_REMOVE,  4'd9,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_PICK,    4'd0,  6'sd0,   0);
        send_cmd(aps_pkg::CMD_APPEND,  4'd3,  6'sd20,  0);
        drain();

        // Random phases: fill, mix, pick-heavy, drain-heavy and so on
        for (p = 0; p < 7; p++)
        begin
            tx_busy = txp[p];
            rx_busy = rxp[p];
            for (k = 0; k < 200; k++)
            begin
                r = int'($urandom_range(0, 99));
                if (r < wa[p])
                    op = aps_pkg::CMD_APPEND;
                else if (r < wa[p] + wr[p])
                    op = aps_pkg::CMD_REMOVE;
                else if (r < wa[p] + wr[p] + ws[p])
                    op = aps_pkg::CMD_SETPRIO;
                else
                    op = aps_pkg::CMD_PICK;
                send_cmd(op, aps_pkg::slot_t'($urandom_range(0, NUM_SLOTS - 1)), rand_prio(),
                         pick_gap(tx_busy));
            end
            drain();
        end

        // Wait out the tail so any stray result word shows up
        rx_busy = 0;
        repeat (24) @(negedge clk);
        if (sb.errors == 0 && sb.waiting() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+sv
sv/aps_pkg.sv
sv/aps_cell.sv
sv/aps_picker.sv
sv/aging_priority_scheduler_top.sv
sv/aps_checker.sv
sim/testbench.sv
